// ===== hdl/rhc_pkg.sv =====
// ----------------------------------------------------------------
// rhc_pkg
// Shared constants and types for the RGB/HSL pixel converter.
// ----------------------------------------------------------------
package rhc_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  localparam int ONE      = 1 << FRAC_BITS;
  localparam int HUE_UNIT = 1 << HUE_FRAC_BITS;
  localparam int HUE_FULL = 360 * HUE_UNIT;
  localparam int HUE_60   = 60 * HUE_UNIT;
  localparam int HUE_120  = 120 * HUE_UNIT;
  localparam int HUE_180  = 180 * HUE_UNIT;
  localparam int HUE_240  = 240 * HUE_UNIT;

  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int Q_W   = 13;

  // pipelined divider: 2 quotient bits per stage
  localparam int DIV_ST = 8;
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 10;
  localparam int DIV_QW = 16;

  // stage where both paths meet, then the output register
  localparam int MRG = DIV_ST + 1;
  localparam int NST = MRG + 1;

  // floor(x/510) for x < 2^21: (x*8224) >> 22, then one correction
  localparam int L_RECIP = 8224;
  localparam int L_SHIFT = 22;
  localparam int L_DEN   = 510;

  // floor(z/15) for z < 4096: (z*2185) >> 15
  localparam int D15_RECIP = 2185;
  localparam int D15_SHIFT = 15;

  typedef logic [NST:1] stage_en_t;

endpackage

// ===== hdl/rhc_if.sv =====
// ----------------------------------------------------------------
// rhc_if
// Request channels of the converter: input pixel and result pixel.
// ----------------------------------------------------------------
interface rhc_in_if;
  import rhc_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [CH_W-1:0]  red_in;
  logic [CH_W-1:0]  green_in;
  logic [CH_W-1:0]  blue_in;
  logic [HUE_W-1:0] hue_in;
  logic [Q_W-1:0]   lightness_in;
  logic [Q_W-1:0]   saturation_in;

  modport source (output valid, mode, red_in, green_in, blue_in, hue_in, lightness_in,
                  saturation_in, input ready);
  modport sink (input valid, mode, red_in, green_in, blue_in, hue_in, lightness_in,
                saturation_in, output ready);
endinterface

interface rhc_out_if;
  import rhc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic [HUE_W-1:0] hue_out;
  logic [Q_W-1:0]   lightness_out;
  logic [Q_W-1:0]   saturation_out;

  modport source (output valid, red_out, green_out, blue_out, hue_out, lightness_out,
                  saturation_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, hue_out, lightness_out,
                saturation_out, output ready);
endinterface

// ===== hdl/rhc_div.sv =====
// ----------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, two quotient bits per stage.
// Quotient must fit in DIV_QW bits.
// ----------------------------------------------------------------
module rhc_div (
  input  logic                       clk,
  input  logic [rhc_pkg::DIV_ST-1:0] en,
  input  logic [rhc_pkg::DIV_NW-1:0] num,
  input  logic [rhc_pkg::DIV_DW-1:0] den,
  output logic [rhc_pkg::DIV_QW-1:0] quo
);
  import rhc_pkg::*;

  localparam int BPS = DIV_QW / DIV_ST;
  localparam int TW  = DIV_DW + DIV_QW;

  logic [DIV_NW-1:0] rem_in [DIV_ST];
  logic [DIV_NW-1:0] rem_n  [DIV_ST];
  logic [DIV_NW-1:0] rem_q  [DIV_ST];
  logic [DIV_DW-1:0] den_in [DIV_ST];
  logic [DIV_DW-1:0] den_q  [DIV_ST];
  logic [DIV_QW-1:0] quo_in [DIV_ST];
  logic [DIV_QW-1:0] quo_n  [DIV_ST];
  logic [DIV_QW-1:0] quo_q  [DIV_ST];

  for (genvar j = 0; j < DIV_ST; j++) begin : g_st
    if (j == 0) begin : g_first
      assign rem_in[j] = num;
      assign den_in[j] = den;
      assign quo_in[j] = '0;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign den_in[j] = den_q[j-1];
      assign quo_in[j] = quo_q[j-1];
    end

    always_comb begin : step
      logic [TW-1:0]     trial;
      logic [DIV_NW-1:0] r;
      logic [DIV_QW-1:0] q;
      r = rem_in[j];
      q = quo_in[j];
      for (int b = 0; b < BPS; b++) begin
        trial = TW'(den_in[j]) << (DIV_QW - 1 - j * BPS - b);
        if (TW'(r) >= trial) begin
          r = r - DIV_NW'(trial);
          q = {q[DIV_QW-2:0], 1'b1};
        end else begin
          q = {q[DIV_QW-2:0], 1'b0};
        end
      end
      rem_n[j] = r;
      quo_n[j] = q;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_q[j] <= rem_n[j];
        den_q[j] <= den_in[j];
        quo_q[j] <= quo_n[j];
      end
    end
  end

  assign quo = quo_q[DIV_ST-1];

endmodule

// ===== hdl/rhc_rgb2hsl.sv =====
// ----------------------------------------------------------------
// rhc_rgb2hsl
// RGB to HSL path: min/max front end, hue and saturation dividers,
// lightness by reciprocal multiply. Results valid at stage MRG.
// ----------------------------------------------------------------
module rhc_rgb2hsl (
  input  logic                       clk,
  input  rhc_pkg::stage_en_t         en,
  input  logic [rhc_pkg::CH_W-1:0]   red,
  input  logic [rhc_pkg::CH_W-1:0]   green,
  input  logic [rhc_pkg::CH_W-1:0]   blue,
  output logic [rhc_pkg::HUE_W-1:0]  hue,
  output logic [rhc_pkg::Q_W-1:0]    lightness,
  output logic [rhc_pkg::Q_W-1:0]    saturation
);
  import rhc_pkg::*;

  // front end
  logic [7:0]        mx, mn, d;
  logic [8:0]        s, sden;
  logic signed [18:0] rr, gg, bb, dd, hn;
  logic [DIV_NW-1:0] hnum_n, snum_n, hnum_q, snum_q;
  logic [DIV_DW-1:0] hden_n, sden_n, hden_q, sden_q;
  logic [20:0]       lx_n, lx1, lx2;
  logic [34:0]       lprod;
  logic [12:0]       qe, lt;
  logic [21:0]       lrem;
  logic [DIV_QW-1:0] hquo, squo;
  logic [Q_W-1:0]    light_q [3:MRG];
  logic              grey_q  [1:MRG];

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    d    = mx - mn;
    s    = 9'(mx) + 9'(mn);
    sden = (s < 9'd255) ? s : 9'd510 - s;
    rr = 19'(red);
    gg = 19'(green);
    bb = 19'(blue);
    dd = 19'(d);
    // red wins ties, then green
    if (mx == red)        hn = 19'sd60 * (gg - bb);
    else if (mx == green) hn = 19'sd60 * (bb - rr) + 19'sd120 * dd;
    else                  hn = 19'sd60 * (rr - gg) + 19'sd240 * dd;
    if (hn < 0) hn = hn + 19'sd360 * dd;
    // round(a/b) = floor((2a+b)/2b)
    hnum_n = 24'({hn[16:0], 7'b0}) + 24'(d);
    hden_n = 10'({d, 1'b0});
    snum_n = 24'({d, 13'b0}) + 24'(sden);
    sden_n = 10'({sden, 1'b0});
    lx_n   = 21'({s, 12'b0}) + 21'd255;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hnum_q    <= hnum_n;
      hden_q    <= hden_n;
      snum_q    <= snum_n;
      sden_q    <= sden_n;
      lx1       <= lx_n;
    end
  end

  rhc_div u_hue_div (
    .clk (clk),
    .en  (en[MRG:2]),
    .num (hnum_q),
    .den (hden_q),
    .quo (hquo)
  );

  rhc_div u_sat_div (
    .clk (clk),
    .en  (en[MRG:2]),
    .num (snum_q),
    .den (sden_q),
    .quo (squo)
  );

  // lightness = floor((s*4096 + 255) / 510)
  always_ff @(posedge clk) begin
    if (en[2]) begin
      lprod <= 35'(lx1) * 35'(L_RECIP);
      lx2   <= lx1;
    end
  end

  always_comb begin
    qe   = lprod[L_SHIFT+12:L_SHIFT];
    lrem = 22'(lx2) - 22'(qe) * 22'(L_DEN);
    lt   = (lrem >= 22'(L_DEN)) ? qe + 13'd1 : qe;
  end

  always_ff @(posedge clk) begin
    if (en[3]) light_q[3] <= lt;
    for (int k = 4; k <= MRG; k++) begin
      if (en[k]) light_q[k] <= light_q[k-1];
    end
    if (en[1]) grey_q[1] <= (d == 8'd0);
    for (int k = 2; k <= MRG; k++) begin
      if (en[k]) grey_q[k] <= grey_q[k-1];
    end
  end

  always_comb begin
    lightness = light_q[MRG];
    if (grey_q[MRG]) begin
      hue        = '0;
      saturation = '0;
    end else begin
      hue        = hquo[HUE_W-1:0];
      saturation = (squo > DIV_QW'(ONE)) ? Q_W'(ONE) : squo[Q_W-1:0];
    end
  end

endmodule

// ===== hdl/rhc_hsl2rgb.sv =====
// ----------------------------------------------------------------
// rhc_hsl2rgb
// HSL to RGB path: clamp, p/q forms, ramp products, rounding to 8 bits.
// Results valid at stage MRG.
// ----------------------------------------------------------------
module rhc_hsl2rgb (
  input  logic                       clk,
  input  rhc_pkg::stage_en_t         en,
  input  logic [rhc_pkg::HUE_W-1:0]  hue,
  input  logic [rhc_pkg::Q_W-1:0]    lightness,
  input  logic [rhc_pkg::Q_W-1:0]    saturation,
  output logic [rhc_pkg::CH_W-1:0]   red,
  output logic [rhc_pkg::CH_W-1:0]   green,
  output logic [rhc_pkg::CH_W-1:0]   blue
);
  import rhc_pkg::*;

  function automatic logic [11:0] ramp_k(input logic [HUE_W-1:0] t);
    logic [11:0] k;
    if (t < HUE_W'(HUE_60))       k = t[11:0];
    else if (t < HUE_W'(HUE_180)) k = 12'(HUE_60);
    else if (t < HUE_W'(HUE_240)) k = 12'(HUE_W'(HUE_240) - t);
    else                          k = '0;
    return k;
  endfunction

  logic [HUE_W-1:0] hc, tr, tb;
  logic [Q_W-1:0]   lc, sc, lc1, sc1;
  logic [21:0]      gtmp;
  logic [7:0]       gc_n;
  logic [25:0]      ls1;
  logic [11:0]      k_n [3];
  logic [11:0]      k1 [3];
  logic [11:0]      k2 [3];
  logic [24:0]      q2, p2_n, dq_n, p2, dq;
  logic [36:0]      pb3, m3 [3];
  logic [36:0]      n4 [3];
  logic [44:0]      y5 [3];
  logic [11:0]      z5 [3];
  logic [23:0]      c6 [3];
  logic [7:0]       ch6 [3];
  logic [7:0]       ch_q [3][6:MRG];
  logic             grey_q [1:5];
  logic [7:0]       gc_q   [1:5];

  // stage 1: clamp, hue offsets, l*s
  always_comb begin
    hc = (hue > HUE_W'(HUE_FULL)) ? HUE_W'(HUE_FULL) : hue;
    lc = (lightness > Q_W'(ONE)) ? Q_W'(ONE) : lightness;
    sc = (saturation > Q_W'(ONE)) ? Q_W'(ONE) : saturation;
    tr = (hc > HUE_W'(HUE_FULL - HUE_120)) ? hc - HUE_W'(HUE_FULL - HUE_120)
                                            : hc + HUE_W'(HUE_120);
    tb = (hc >= HUE_W'(HUE_120)) ? hc - HUE_W'(HUE_120)
                                 : hc + HUE_W'(HUE_FULL - HUE_120);
    k_n[0] = ramp_k(tr);
    k_n[1] = ramp_k(hc);
    k_n[2] = ramp_k(tb);
    gtmp = 22'(lc) * 22'(510) + 22'(ONE);
    gc_n = (gtmp[21:13] > 9'd255) ? 8'd255 : gtmp[20:13];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lc1       <= lc;
      sc1       <= sc;
      ls1       <= 26'(lc) * 26'(sc);
      k1        <= k_n;
    end
  end

  // stage 2: q and p in Q24
  always_comb begin
    if ({lc1, 1'b0} < 14'(ONE)) q2 = 25'({lc1, 12'b0}) + 25'(ls1);
    else q2 = 25'({lc1, 12'b0}) + 25'({sc1, 12'b0}) - 25'(ls1);
    p2_n = 25'({lc1, 13'b0}) - q2;
    dq_n = q2 - p2_n;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2 <= p2_n;
      dq <= dq_n;
      k2 <= k1;
    end
  end

  // stage 3: ramp products
  always_ff @(posedge clk) begin
    if (en[3]) begin
      pb3 <= 37'(p2) * 37'(HUE_60);
      for (int c = 0; c < 3; c++) m3[c] <= 37'(dq) * 37'(k2[c]);
    end
  end

  // stage 4: numerators
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 3; c++) n4[c] <= pb3 + m3[c];
    end
  end

  // stage 5: scale by 255, add half the divisor (15 * 2^31), drop 2^32
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      y5[c] = 45'(n4[c]) * 45'(255) + (45'(15) << 31);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 3; c++) z5[c] <= y5[c][43:32];
    end
  end

  // stage 6: divide by 15, clamp, grey override
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      c6[c] = 24'(z5[c]) * 24'(D15_RECIP);
      if (grey_q[5]) ch6[c] = gc_q[5];
      else if (c6[c][D15_SHIFT+8:D15_SHIFT] > 9'd255) ch6[c] = 8'd255;
      else ch6[c] = c6[c][D15_SHIFT+7:D15_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      grey_q[1] <= (sc == '0);
      gc_q[1]   <= gc_n;
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        grey_q[k] <= grey_q[k-1];
        gc_q[k]   <= gc_q[k-1];
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (en[6]) ch_q[c][6] <= ch6[c];
      for (int k = 7; k <= MRG; k++) begin
        if (en[k]) ch_q[c][k] <= ch_q[c][k-1];
      end
    end
  end

  assign red   = ch_q[0][MRG];
  assign green = ch_q[1][MRG];
  assign blue  = ch_q[2][MRG];

endmodule

// ===== hdl/rgb_hsl_color_converter.sv =====
// ----------------------------------------------------------------
// rgb_hsl_color_converter
// A result passes stage 1, the divider stages and the output register before it is valid.
// Throughput: one pixel per clock while the receiver holds ready; the divider pipeline sets the depth.
// Stages advance independently, so bubbles fill while a result waits.
// Reset clears only the stage valid bits; the datapath is not reset.
// ----------------------------------------------------------------
module rgb_hsl_color_converter (
  input logic       clk,
  input logic       rst,
  rhc_in_if.sink    pix_in,
  rhc_out_if.source pix_out
);
  import rhc_pkg::*;

  stage_en_t        en;
  logic [NST:1]     vld;
  logic             mode_q [1:MRG];
  logic [HUE_W-1:0] r2h_hue;
  logic [Q_W-1:0]   r2h_light, r2h_sat;
  logic [CH_W-1:0]  h2r_red, h2r_green, h2r_blue;
  logic [CH_W-1:0]  red_q, green_q, blue_q;
  logic [HUE_W-1:0] hue_q;
  logic [Q_W-1:0]   light_q, sat_q;

  // a stage may load when empty or when the next one moves
  always_comb begin
    en[NST] = !vld[NST] || pix_out.ready;
    for (int k = NST - 1; k >= 1; k--) en[k] = !vld[k] || en[k+1];
  end

  assign pix_in.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= pix_in.valid;
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) mode_q[1] <= pix_in.mode;
    for (int k = 2; k <= MRG; k++) begin
      if (en[k]) mode_q[k] <= mode_q[k-1];
    end
  end

  rhc_rgb2hsl u_rgb2hsl (
    .clk        (clk),
    .en         (en),
    .red        (pix_in.red_in),
    .green      (pix_in.green_in),
    .blue       (pix_in.blue_in),
    .hue        (r2h_hue),
    .lightness  (r2h_light),
    .saturation (r2h_sat)
  );

  rhc_hsl2rgb u_hsl2rgb (
    .clk        (clk),
    .en         (en),
    .hue        (pix_in.hue_in),
    .lightness  (pix_in.lightness_in),
    .saturation (pix_in.saturation_in),
    .red        (h2r_red),
    .green      (h2r_green),
    .blue       (h2r_blue)
  );

  // output register; fields of the other direction read zero
  always_ff @(posedge clk) begin
    if (en[NST]) begin
      if (mode_q[MRG]) begin
        red_q   <= h2r_red;
        green_q <= h2r_green;
        blue_q  <= h2r_blue;
        hue_q   <= '0;
        light_q <= '0;
        sat_q   <= '0;
      end else begin
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
        hue_q   <= r2h_hue;
        light_q <= r2h_light;
        sat_q   <= r2h_sat;
      end
    end
  end

  assign pix_out.valid          = vld[NST];
  assign pix_out.red_out        = red_q;
  assign pix_out.green_out      = green_q;
  assign pix_out.blue_out       = blue_q;
  assign pix_out.hue_out        = hue_q;
  assign pix_out.lightness_out  = light_q;
  assign pix_out.saturation_out = sat_q;

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> vld[1])
    else $error("accepted request did not enter stage 1");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.saturation_out <= Q_W'(ONE))
    else $error("saturation above 1.0");

  a_light_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.lightness_out <= Q_W'(ONE))
    else $error("lightness above 1.0");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.hue_out <= HUE_W'(HUE_FULL))
    else $error("hue above full turn");

endmodule

// ===== tb/rgb_hsl_color_converter_test.sv =====
// ----------------------------------------------------------------
// rgb_hsl_color_converter_test
// Drives RGB and HSL pixels through the converter with random gaps
// and stalls on both sides, and checks every result against typed-in values
// or an exact integer model of both conversions.
// ----------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hsl_color_converter_test;
  import rhc_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1750;

  typedef struct packed {
    logic             mode;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [HUE_W-1:0] h;
    logic [Q_W-1:0]   l;
    logic [Q_W-1:0]   s;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [HUE_W-1:0] h;
    logic [Q_W-1:0]   l;
    logic [Q_W-1:0]   s;
  } color_t;

  // directed row: pixel, whether the expected result is typed in, that result
  typedef struct packed {
    pixel_t px;
    logic   fixed;
    color_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhc_in_if  pix_in ();
  rhc_out_if pix_out ();

  rgb_hsl_color_converter DUT (
    .clk(clk),
    .rst(rst),
    .pix_in(pix_in.sink),
    .pix_out(pix_out.source)
  );

  always #5 clk = ~clk;

  color_t expected_colors[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     feeding_done = 1'b0;
  bit     hold_off = 1'b0;
  row_t   rows[$];

  function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic longint unsigned ramp(longint t, longint unsigned p2,
                                          longint unsigned q2);
    longint unsigned k;
    longint unsigned c;
    if (t < HUE_60) k = t;
    else if (t < HUE_180) k = HUE_60;
    else if (t < HUE_240) k = HUE_240 - t;
    else k = 0;
    c = rdiv((p2 * HUE_60 + (q2 - p2) * k) * 255, longint'(ONE) * ONE * HUE_60);
    return (c > 255) ? 255 : c;
  endfunction

  function automatic longint wrap_turn(longint t);
    if (t < 0) t += HUE_FULL;
    if (t > HUE_FULL) t -= HUE_FULL;
    return t;
  endfunction

  function automatic color_t convert_pixel(pixel_t px);
    color_t c;
    longint unsigned r, g, b, mx, mn, d, sm, sden, sat, h, l, s, q2, p2;
    longint num;
    c = '0;
    if (!px.mode) begin
      r = px.r; g = px.g; b = px.b;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      if (d == 0) begin
        c.l = Q_W'(rdiv(mn * ONE, 255));
      end else begin
        sm = mx + mn;
        c.l = Q_W'(rdiv(sm * ONE, 510));
        sden = (sm < 255) ? sm : 510 - sm;
        sat = rdiv(d * ONE, sden);
        c.s = Q_W'((sat > ONE) ? ONE : sat);
        if (mx == r) num = 60 * (longint'(g) - longint'(b));
        else if (mx == g) num = 60 * (longint'(b) - longint'(r)) + 120 * longint'(d);
        else num = 60 * (longint'(r) - longint'(g)) + 240 * longint'(d);
        if (num < 0) num += 360 * longint'(d);
        c.h = HUE_W'(rdiv(num * HUE_UNIT, d));
      end
    end else begin
      h = (px.h > HUE_FULL) ? HUE_FULL : px.h;
      l = (px.l > ONE) ? ONE : px.l;
      s = (px.s > ONE) ? ONE : px.s;
      if (s == 0) begin
        c.r = CH_W'(rdiv(l * 255, ONE));
        c.g = c.r;
        c.b = c.r;
      end else begin
        if (2 * l < ONE) q2 = l * (ONE + s);
        else q2 = (l + s) * ONE - l * s;
        p2 = 2 * l * ONE - q2;
        c.r = CH_W'(ramp(wrap_turn(longint'(h) + HUE_120), p2, q2));
        c.g = CH_W'(ramp(wrap_turn(longint'(h)), p2, q2));
        c.b = CH_W'(ramp(wrap_turn(longint'(h) - HUE_120), p2, q2));
      end
    end
    return c;
  endfunction

  function automatic pixel_t rgb_px(int r, int g, int b);
    pixel_t p;
    p = '0;
    p.r = CH_W'(r); p.g = CH_W'(g); p.b = CH_W'(b);
    return p;
  endfunction

  function automatic pixel_t hsl_px(int h, int l, int s);
    pixel_t p;
    p = '0;
    p.mode = 1'b1;
    p.h = HUE_W'(h); p.l = Q_W'(l); p.s = Q_W'(s);
    return p;
  endfunction

  function automatic color_t col(int r, int g, int b, int h, int l, int s);
    color_t c;
    c.r = CH_W'(r); c.g = CH_W'(g); c.b = CH_W'(b);
    c.h = HUE_W'(h); c.l = Q_W'(l); c.s = Q_W'(s);
    return c;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = pixel_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 9))
      0: begin p.g = p.r; p.b = p.r; end
      1: p.s = '0;
      2: p.h = HUE_W'($urandom_range(HUE_FULL - 200, HUE_FULL));
      default: begin
        if (p.mode) begin
          if ($urandom_range(0, 7) != 0) begin
            p.h = HUE_W'($urandom_range(0, HUE_FULL));
            p.l = Q_W'($urandom_range(0, ONE));
            p.s = Q_W'($urandom_range(0, ONE));
          end
        end
      end
    endcase
    return p;
  endfunction

  task automatic build_rows();
    rows.push_back({rgb_px(0, 0, 0), 1'b1, col(0, 0, 0, 0, 0, 0)});
    rows.push_back({rgb_px(255, 255, 255), 1'b1, col(0, 0, 0, 0, ONE, 0)});
    rows.push_back({rgb_px(255, 0, 0), 1'b1, col(0, 0, 0, 0, ONE / 2, ONE)});
    rows.push_back({rgb_px(0, 255, 0), 1'b1, col(0, 0, 0, HUE_120, ONE / 2, ONE)});
    rows.push_back({rgb_px(0, 0, 255), 1'b1, col(0, 0, 0, HUE_240, ONE / 2, ONE)});
    rows.push_back({rgb_px(128, 128, 128), 1'b0, color_t'('0)});
    rows.push_back({rgb_px(255, 0, 1), 1'b0, color_t'('0)});   // hue near a full turn
    rows.push_back({rgb_px(255, 255, 0), 1'b0, color_t'('0)}); // red and green tie
    rows.push_back({rgb_px(0, 255, 255), 1'b0, color_t'('0)});
    rows.push_back({rgb_px(255, 254, 254), 1'b0, color_t'('0)});
    rows.push_back({rgb_px(1, 0, 0), 1'b0, color_t'('0)});
    rows.push_back({hsl_px(0, 0, 0), 1'b1, col(0, 0, 0, 0, 0, 0)});
    rows.push_back({hsl_px(0, ONE, 0), 1'b1, col(255, 255, 255, 0, 0, 0)});
    rows.push_back({hsl_px(0, ONE / 2, ONE), 1'b1, col(255, 0, 0, 0, 0, 0)});
    rows.push_back({hsl_px(HUE_120, ONE / 2, ONE), 1'b1, col(0, 255, 0, 0, 0, 0)});
    rows.push_back({hsl_px(HUE_240, ONE / 2, ONE), 1'b1, col(0, 0, 255, 0, 0, 0)});
    rows.push_back({hsl_px(HUE_FULL, ONE / 2, ONE), 1'b1, col(255, 0, 0, 0, 0, 0)});
    rows.push_back({hsl_px(32767, 8191, 8191), 1'b0, color_t'('0)}); // saturating inputs
    rows.push_back({hsl_px(1000, 2048, 0), 1'b0, color_t'('0)});
    rows.push_back({hsl_px(5000, 1000, 3000), 1'b0, color_t'('0)});
    rows.push_back({hsl_px(17000, 3500, 4096), 1'b0, color_t'('0)});
    rows.push_back({hsl_px(HUE_60, 2047, 1), 1'b0, color_t'('0)});
  endtask

  // valid drops only for a gap, so back-to-back requests keep it high
  task automatic send_pixel(pixel_t px, color_t res);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in.valid         <= 1'b1;
    pix_in.mode          <= px.mode;
    pix_in.red_in        <= px.r;
    pix_in.green_in      <= px.g;
    pix_in.blue_in       <= px.b;
    pix_in.hue_in        <= px.h;
    pix_in.lightness_in  <= px.l;
    pix_in.saturation_in <= px.s;
    do @(posedge clk); while (!pix_in.ready);
    expected_colors.push_back(res);
    @(negedge clk);
  endtask

  initial begin
    pix_in.valid = 1'b0;
    pix_in.mode = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.hue_in = '0;
    pix_in.lightness_in = '0;
    pix_in.saturation_in = '0;
    build_rows();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i])
      send_pixel(rows[i].px, rows[i].fixed ? rows[i].res : convert_pixel(rows[i].px));
    for (int i = 0; i < N_RANDOM; i++) begin
      pixel_t p;
      p = random_pixel();
      if (i == 600) hold_off = 1'b1;
      send_pixel(p, convert_pixel(p));
    end
    pix_in.valid <= 1'b0;
    feeding_done = 1'b1;
  end

  // receiver: random stalls, plus one long hold-off to back up the pipe
  initial begin
    int n;
    pix_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        pix_out.ready <= 1'b0;
        repeat (150) @(negedge clk);
      end
      n = $urandom_range(0, 9);
      if (n == 0) begin
        pix_out.ready <= 1'b0;
        repeat ($urandom_range(5, 40)) @(negedge clk);
        pix_out.ready <= 1'b1;
      end else begin
        pix_out.ready <= (n > 2);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      color_t got, want;
      got = {pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.hue_out,
             pix_out.lightness_out, pix_out.saturation_out};
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_colors.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rgb %0d %0d %0d hsl %0d %0d %0d, want %0d %0d %0d %0d %0d %0d",
                     got.r, got.g, got.b, got.h, got.l, got.s,
                     want.r, want.g, want.b, want.h, want.l, want.s);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (feeding_done && expected_colors.size() == 0 || idle_cycles >= WATCHDOG);
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
    end else begin
      repeat (3 * NST) @(posedge clk);
      if (mismatches == 0 && expected_colors.size() == 0) $display("tb: success");
      else $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rhc_pkg.sv
hdl/rhc_if.sv
hdl/rhc_div.sv
hdl/rhc_rgb2hsl.sv
hdl/rhc_hsl2rgb.sv
hdl/rgb_hsl_color_converter.sv
tb/rgb_hsl_color_converter_test.sv
